>>> sv/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg: shared types and constants for the UTF-8 stream decoder
// Result kinds, lead-byte masks, and the decoder state and result records.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CP_WIDTH    = 31;

   typedef enum logic [1:0] {
      KIND_CODE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   localparam logic [7:0] CONT_MASK = 8'h3F;
   localparam logic [7:0] LEAD2_MASK = 8'h1F;
   localparam logic [7:0] LEAD3_MASK = 8'h0F;
   localparam logic [7:0] LEAD4_MASK = 8'h07;
   localparam logic [7:0] LEAD5_MASK = 8'h03;
   localparam logic [7:0] LEAD6_MASK = 8'h01;

   typedef struct packed {
      logic [CP_WIDTH-1:0]    acc;
      logic [2:0]             remaining;
      logic [COUNT_WIDTH-1:0] count;
      logic                   skipping;
   } state_type;

   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic [CP_WIDTH-1:0]    code_point;
      logic [COUNT_WIDTH-1:0] char_count;
   } result_type;

endpackage

>>> sv/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: byte-serial UTF-8 decoder, one to six byte form
// Input register, one-byte decode step, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one byte of a zero-terminated UTF-8 string per transfer.
//   rsp_*  : at most one result per byte: a code point when a sequence
//            completes, end of string with the character count (terminator
//            included, saturating), or an error with count 0.
//   csr_*  : narrow_mode write, taken on any edge with csr_wr_en high; write
//            it only while the block is idle.
// Path: a byte's transfer loads the input register, which feeds the decode
//   step; the step loads the result register, which presents the result.
//   Throughput: one byte per cycle while no result waits on rsp_ready; the
//   decode step is a single mask/shift/merge between the two registers.
// Stall: while rsp_valid waits on rsp_ready, a byte that produces no result
//   still advances; a byte that produces one holds in the input register,
//   and req_ready drops only once that register is also occupied.
// Reset: synchronous; clears both register valid bits, the decoder state and
//   narrow_mode. Bytes after an invalid lead are dropped up to the next zero.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_byte_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_result_kind,
   output logic [utf8sd_pkg::CP_WIDTH-1:0]    rsp_code_point,
   output logic [utf8sd_pkg::COUNT_WIDTH-1:0] rsp_char_count,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // decoder state and mode
   utf8sd_pkg::state_type state_ff, state_in;
   logic                  narrow_ff, narrow_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   utf8sd_pkg::kind_type                rsp_kind_ff, rsp_kind_in;
   logic [utf8sd_pkg::CP_WIDTH-1:0]     rsp_cp_ff, rsp_cp_in;
   logic [utf8sd_pkg::COUNT_WIDTH-1:0]  rsp_cnt_ff, rsp_cnt_in;

   utf8sd_pkg::state_type  step_state;
   utf8sd_pkg::result_type step_result;
   logic                   rsp_free;
   logic                   advance;

   utf8sd_step u_step (
      .state_cur   (state_ff),
      .byte_cur    (in_byte_ff),
      .narrow_mode (narrow_ff),
      .state_nxt   (step_state),
      .result      (step_result)
   );

   // result slot is free if empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   // advance the held byte unless it has a result with nowhere to go
   assign advance  = in_valid_ff && (!step_result.valid || rsp_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      narrow_in    = narrow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cp_in    = rsp_cp_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (csr_wr_en) begin
         narrow_in = csr_wr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         state_in    = step_state;
         in_valid_in = 1'b0;
         if (step_result.valid) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = step_result.kind;
            rsp_cp_in    = step_result.code_point;
            rsp_cnt_in   = step_result.char_count;
         end
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         narrow_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         narrow_ff    <= narrow_in;
      end
      in_byte_ff  <= in_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cp_ff   <= rsp_cp_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_code_point  = rsp_cp_ff;
   assign rsp_char_count  = rsp_cnt_ff;

endmodule

>>> sv/utf8sd_step.sv
// ----------------------------------------------------------------------------
// utf8sd_step: one-byte decode step
// Combinational next state and optional result for one byte of the string.
// ----------------------------------------------------------------------------
module utf8sd_step (
   input  utf8sd_pkg::state_type  state_cur,
   input  logic [7:0]             byte_cur,
   input  logic                   narrow_mode,
   output utf8sd_pkg::state_type  state_nxt,
   output utf8sd_pkg::result_type result
);

   logic [utf8sd_pkg::COUNT_WIDTH-1:0] count_inc;
   logic [utf8sd_pkg::CP_WIDTH-1:0]    acc_shift;
   logic [7:0]                         cont_bits;

   assign count_inc = (state_cur.count == '1) ? state_cur.count
                                              : state_cur.count + 1'b1;
   assign cont_bits = byte_cur & utf8sd_pkg::CONT_MASK;
   assign acc_shift = {state_cur.acc[utf8sd_pkg::CP_WIDTH-7:0], cont_bits[5:0]};

   always_comb begin
      state_nxt         = state_cur;
      result.valid      = 1'b0;
      result.kind       = utf8sd_pkg::KIND_CODE;
      result.code_point = '0;
      result.char_count = '0;

      if (state_cur.skipping) begin
         // drop bytes until the terminator
         if (byte_cur == 8'h00) begin
            state_nxt.skipping = 1'b0;
            state_nxt.count    = '0;
         end
      end else if (state_cur.remaining != 3'd0) begin
         if (byte_cur == 8'h00) begin
            // terminator cut a sequence short
            state_nxt.remaining = 3'd0;
            state_nxt.acc       = '0;
            state_nxt.count     = '0;
            result.valid        = 1'b1;
            result.kind         = utf8sd_pkg::KIND_ERROR;
         end else begin
            state_nxt.remaining = state_cur.remaining - 3'd1;
            if (state_cur.remaining == 3'd1) begin
               state_nxt.acc     = '0;
               result.valid      = 1'b1;
               result.code_point = acc_shift;
            end else begin
               state_nxt.acc = acc_shift;
            end
         end
      end else if (byte_cur == 8'h00) begin
         state_nxt.count   = '0;
         result.valid      = 1'b1;
         result.kind       = utf8sd_pkg::KIND_END;
         result.char_count = count_inc;
      end else begin
         case (byte_cur) inside
            8'b0???????: begin
               state_nxt.count   = count_inc;
               result.valid      = 1'b1;
               result.code_point = {{(utf8sd_pkg::CP_WIDTH-8){1'b0}}, byte_cur};
            end
            8'b110?????: begin
               state_nxt.count     = count_inc;
               state_nxt.remaining = 3'd1;
               state_nxt.acc       = {{(utf8sd_pkg::CP_WIDTH-8){1'b0}},
                                      byte_cur & utf8sd_pkg::LEAD2_MASK};
            end
            8'b1110????: begin
               state_nxt.count     = count_inc;
               state_nxt.remaining = 3'd2;
               state_nxt.acc       = {{(utf8sd_pkg::CP_WIDTH-8){1'b0}},
                                      byte_cur & utf8sd_pkg::LEAD3_MASK};
            end
            8'b11110???, 8'b111110??, 8'b1111110?: begin
               if (narrow_mode) begin
                  state_nxt.skipping = 1'b1;
                  state_nxt.count    = '0;
                  state_nxt.acc      = '0;
                  result.valid       = 1'b1;
                  result.kind        = utf8sd_pkg::KIND_ERROR;
               end else begin
                  state_nxt.count = count_inc;
                  if (byte_cur[3] == 1'b0) begin
                     state_nxt.remaining = 3'd3;
                     state_nxt.acc       = {{(utf8sd_pkg::CP_WIDTH-8){1'b0}},
                                            byte_cur & utf8sd_pkg::LEAD4_MASK};
                  end else if (byte_cur[2] == 1'b0) begin
                     state_nxt.remaining = 3'd4;
                     state_nxt.acc       = {{(utf8sd_pkg::CP_WIDTH-8){1'b0}},
                                            byte_cur & utf8sd_pkg::LEAD5_MASK};
                  end else begin
                     state_nxt.remaining = 3'd5;
                     state_nxt.acc       = {{(utf8sd_pkg::CP_WIDTH-8){1'b0}},
                                            byte_cur & utf8sd_pkg::LEAD6_MASK};
                  end
               end
            end
            default: begin
               // stray continuation byte or 0xFE/0xFF
               state_nxt.skipping = 1'b1;
               state_nxt.count    = '0;
               state_nxt.acc      = '0;
               result.valid       = 1'b1;
               result.kind        = utf8sd_pkg::KIND_ERROR;
            end
         endcase
      end
   end

endmodule

>>> sv/utf8sd_checker.sv
// ----------------------------------------------------------------------------
// utf8sd_checker: port-level checks for the UTF-8 stream decoder
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module utf8sd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_result_kind,
   input logic [utf8sd_pkg::CP_WIDTH-1:0]    rsp_code_point,
   input logic [utf8sd_pkg::COUNT_WIDTH-1:0] rsp_char_count
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_code_point) && $stable(rsp_char_count))
      else $error("stalled result changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result presented right after reset");

   // end of string always counts at least the terminator
   a_end_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == utf8sd_pkg::KIND_END
         |-> rsp_char_count != '0 && rsp_code_point == '0)
      else $error("end of string with zero count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == utf8sd_pkg::KIND_ERROR
         || rsp_result_kind == utf8sd_pkg::KIND_CODE) |-> rsp_char_count == '0)
      else $error("count reported outside end of string");

endmodule

bind utf8_stream_decoder_unit utf8sd_checker u_utf8sd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_code_point  (rsp_code_point),
   .rsp_char_count  (rsp_char_count)
);

>>> verif/utf8_stream_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_test: self-checking bench for the UTF-8 decoder
// Feeds zero-terminated byte strings over the request channel and compares
// every result transfer against a bit-accurate decoder kept in the bench.
// A short table of directed bytes comes first. Random strings follow in both
// widths of the narrow_mode register, with random idling on both sides and a
// long hold-off on the result side.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit_test;

   localparam int CP_WIDTH      = utf8sd_pkg::CP_WIDTH;
   localparam int COUNT_WIDTH   = utf8sd_pkg::COUNT_WIDTH;
   // Stop the run here even if the block hangs. A correct run is far shorter.
   localparam int LIMIT_CYCLES  = 2000000;
   // Give bytes that make no result time to drain before a register write.
   localparam int SETTLE_CYCLES = 4;
   // Length of the result side hold-off that fills the block.
   localparam int HOLD_CYCLES   = 200;
   // Counted bytes per random phase.
   localparam int PHASE_BYTES   = 240;
   localparam int DIR_ROWS      = 26;

   typedef struct packed {
      utf8sd_pkg::kind_type   kind;
      logic [CP_WIDTH-1:0]    code_point;
      logic [COUNT_WIDTH-1:0] char_count;
   } decoded_item_type;

   // Register write to make before a directed byte.
   typedef enum logic [1:0] {
      MODE_KEEP,
      MODE_NARROW,
      MODE_WIDE
   } mode_act_type;

   typedef struct {
      mode_act_type     act;
      logic [7:0]       data;
      bit               typed;
      decoded_item_type res;
   } stim_row_type;

   localparam decoded_item_type NO_RESULT = '{utf8sd_pkg::KIND_CODE, '0, '0};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_byte_in;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_result_kind;
   logic [CP_WIDTH-1:0]    rsp_code_point;
   logic [COUNT_WIDTH-1:0] rsp_char_count;
   logic                   csr_wr_en;
   logic                   csr_wr_data;

   // Bench copy of the decoder state and of narrow_mode.
   logic [CP_WIDTH-1:0]    dec_acc;
   logic [2:0]             dec_left;
   logic [COUNT_WIDTH-1:0] dec_chars;
   bit                     dec_dropping;
   bit                     dec_narrow;

   decoded_item_type pending_results[$];
   int               mismatch_count;
   int               live_bytes;
   int               cycle_count;
   bit               pressure_pending;

   // Directed bytes. Results are typed in only where they are plain to see;
   // every other row is checked against the bench decoder.
   stim_row_type directed_rows [DIR_ROWS] = '{
      // empty string right after reset
      '{MODE_KEEP,   8'h00, 1'b1, '{utf8sd_pkg::KIND_END,   '0,            16'd1}},
      // a letter and the highest single-byte character
      '{MODE_KEEP,   8'h41, 1'b1, '{utf8sd_pkg::KIND_CODE,  31'h41,        '0}},
      '{MODE_KEEP,   8'h7F, 1'b1, '{utf8sd_pkg::KIND_CODE,  31'h7F,        '0}},
      // two-byte character
      '{MODE_KEEP,   8'hC3, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hA9, 1'b0, NO_RESULT},
      // six-byte lead with all payload bits set: largest code point
      '{MODE_KEEP,   8'hFD, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b1, '{utf8sd_pkg::KIND_CODE,  31'h7FFF_FFFF, '0}},
      // end of a string of four characters
      '{MODE_KEEP,   8'h00, 1'b0, NO_RESULT},
      // zero inside a sequence ends the string with an error
      '{MODE_KEEP,   8'hE2, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'h00, 1'b1, '{utf8sd_pkg::KIND_ERROR, '0,            '0}},
      // stray continuation as lead, then dropped bytes up to the zero
      '{MODE_KEEP,   8'h80, 1'b1, '{utf8sd_pkg::KIND_ERROR, '0,            '0}},
      '{MODE_KEEP,   8'h41, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'h00, 1'b0, NO_RESULT},
      // top byte is never a lead
      '{MODE_KEEP,   8'hFF, 1'b1, '{utf8sd_pkg::KIND_ERROR, '0,            '0}},
      '{MODE_KEEP,   8'h00, 1'b0, NO_RESULT},
      // four-byte lead is refused in narrow mode
      '{MODE_NARROW, 8'hF0, 1'b1, '{utf8sd_pkg::KIND_ERROR, '0,            '0}},
      '{MODE_KEEP,   8'h00, 1'b0, NO_RESULT},
      // four-byte lead taken in wide mode, mode flipped mid-sequence
      '{MODE_WIDE,   8'hF4, 1'b0, NO_RESULT},
      '{MODE_NARROW, 8'h8F, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'hBF, 1'b0, NO_RESULT},
      '{MODE_KEEP,   8'h00, 1'b0, NO_RESULT}
   };

   utf8_stream_decoder_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_code_point  (rsp_code_point),
      .rsp_char_count  (rsp_char_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   // Advance the bench decoder by one byte; return 1 when the byte makes a
   // result, and the result in r.
   function automatic bit decode_step(input logic [7:0] b, output decoded_item_type r);
      logic [CP_WIDTH-1:0] seed;
      logic [2:0]          extra;
      bit                  lead_ok;
      r = NO_RESULT;
      seed = '0;
      extra = '0;
      lead_ok = 1'b1;
      // After a bad lead, drop everything up to and including the zero.
      if (dec_dropping) begin
         if (b == 8'h00) begin
            dec_dropping = 1'b0;
            dec_chars = '0;
         end
         return 1'b0;
      end
      // Inside a sequence: merge six payload bits, top bits are not checked.
      if (dec_left != 3'd0) begin
         if (b == 8'h00) begin
            dec_left = '0;
            dec_acc = '0;
            dec_chars = '0;
            r.kind = utf8sd_pkg::KIND_ERROR;
            return 1'b1;
         end
         dec_acc = {dec_acc[CP_WIDTH-7:0], b[5:0]};
         dec_left = dec_left - 3'd1;
         if (dec_left == 3'd0) begin
            r.code_point = dec_acc;
            dec_acc = '0;
            return 1'b1;
         end
         return 1'b0;
      end
      if (b == 8'h00) begin
         r.kind = utf8sd_pkg::KIND_END;
         r.char_count = bump_count(dec_chars);
         dec_chars = '0;
         return 1'b1;
      end
      if (!b[7]) begin
         dec_chars = bump_count(dec_chars);
         r.code_point = CP_WIDTH'(b);
         return 1'b1;
      end
      // Lead byte: the run of leading ones gives the sequence length.
      if (b[7:5] == 3'b110) begin
         seed = CP_WIDTH'(b[4:0]);
         extra = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
         seed = CP_WIDTH'(b[3:0]);
         extra = 3'd2;
      end else if (b[7:3] == 5'b11110 && !dec_narrow) begin
         seed = CP_WIDTH'(b[2:0]);
         extra = 3'd3;
      end else if (b[7:2] == 6'b111110 && !dec_narrow) begin
         seed = CP_WIDTH'(b[1:0]);
         extra = 3'd4;
      end else if (b[7:1] == 7'b1111110 && !dec_narrow) begin
         seed = CP_WIDTH'(b[0]);
         extra = 3'd5;
      end else begin
         lead_ok = 1'b0;
      end
      if (!lead_ok) begin
         dec_dropping = 1'b1;
         dec_chars = '0;
         dec_acc = '0;
         r.kind = utf8sd_pkg::KIND_ERROR;
         return 1'b1;
      end
      dec_chars = bump_count(dec_chars);
      dec_acc = seed;
      dec_left = extra;
      return 1'b0;
   endfunction

   // Offer one byte, hold it until the transfer, then predict its result.
   // A typed row replaces the prediction with the result written in the row.
   task automatic feed(input logic [7:0] b, input bit typed = 1'b0,
                       input decoded_item_type typed_res = NO_RESULT);
      int               gap;
      bit               was_dropping;
      bit               has;
      decoded_item_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      was_dropping = dec_dropping;
      has = decode_step(b, res);
      if (typed) begin
         res = typed_res;
         has = 1'b1;
      end
      if (has)
         pending_results.push_back(res);
      // Dropped bytes do not count toward the phase length.
      if (!was_dropping)
         live_bytes++;
      @(negedge clock);
   endtask

   // Write narrow_mode only once the block has gone idle.
   task automatic switch_mode(input bit narrow);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= narrow;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      dec_narrow = narrow;
   endtask

   function automatic logic [7:0] lead_byte(input int len);
      case (len)
         1:       return 8'($urandom_range(1, 127));
         2:       return 8'hC0 | 8'($urandom_range(0, 31));
         3:       return 8'hE0 | 8'($urandom_range(0, 15));
         4:       return 8'hF0 | 8'($urandom_range(0, 7));
         5:       return 8'hF8 | 8'($urandom_range(0, 3));
         default: return 8'hFC | 8'($urandom_range(0, 1));
      endcase
   endfunction

   // Mostly proper continuations; now and then any nonzero byte, since the
   // top two bits are masked off and never checked.
   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom_range(1, 255));
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // One whole character of a length the current mode allows.
   task automatic emit_char();
      int len;
      len = dec_narrow ? $urandom_range(1, 3) : $urandom_range(1, 6);
      feed(lead_byte(len));
      repeat (len - 1) feed(cont_byte());
   endtask

   // One random piece: mostly proper strings, then cut sequences, bad leads
   // and raw noise.
   task automatic emit_piece();
      int r;
      int len;
      logic [7:0] bad;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         repeat ($urandom_range(0, 6)) emit_char();
         feed(8'h00);
      end else if (r < 88) begin
         // cut a sequence short with the terminator
         repeat ($urandom_range(0, 3)) emit_char();
         len = dec_narrow ? $urandom_range(2, 3) : $urandom_range(2, 6);
         feed(lead_byte(len));
         repeat ($urandom_range(0, len - 2)) feed(cont_byte());
         feed(8'h00);
      end else if (r < 95) begin
         repeat ($urandom_range(0, 3)) emit_char();
         case ($urandom_range(0, 2))
            0:       bad = 8'h80 | 8'($urandom_range(0, 63));
            1:       bad = 8'hFE | 8'($urandom_range(0, 1));
            default: bad = dec_narrow ? 8'($urandom_range(8'hF0, 8'hFD))
                                      : 8'h80 | 8'($urandom_range(0, 63));
         endcase
         feed(bad);
         repeat ($urandom_range(0, 5)) feed(8'($urandom_range(0, 255)));
         feed(8'h00);
      end else begin
         repeat ($urandom_range(1, 8)) feed(8'($urandom_range(0, 255)));
      end
   endtask

   // With press set, the result side holds off just as the phase starts
   // sending, so the block fills and stalls its input.
   task automatic random_phase(input bit narrow, input bit press = 1'b0);
      switch_mode(narrow);
      if (press)
         pressure_pending = 1'b1;
      live_bytes = 0;
      while (live_bytes < PHASE_BYTES) emit_piece();
   endtask

   // Give up on a hung block.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL utf8_stream_decoder_unit");
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, and a field
   // by field check of every result transfer against the oldest prediction.
   initial begin : result_side
      int               stall;
      decoded_item_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (pressure_pending) begin
            pressure_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no result, actual kind %0d code point %h count %0d",
                        $time, rsp_result_kind, rsp_code_point, rsp_char_count);
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  mismatch_count++;
                  $display("%0t: result_kind expected %0d actual %0d",
                           $time, want.kind, rsp_result_kind);
               end
               if (rsp_code_point !== want.code_point) begin
                  mismatch_count++;
                  $display("%0t: code_point expected %h actual %h",
                           $time, want.code_point, rsp_code_point);
               end
               if (rsp_char_count !== want.char_count) begin
                  mismatch_count++;
                  $display("%0t: char_count expected %0d actual %0d",
                           $time, want.char_count, rsp_char_count);
               end
            end
         end
         @(negedge clock);
      end
   end

   // Request side and phase sequencing.
   initial begin : request_side
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_in = 8'h00;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      dec_acc = '0;
      dec_left = '0;
      dec_chars = '0;
      dec_dropping = 1'b0;
      dec_narrow = 1'b0;
      mismatch_count = 0;
      live_bytes = 0;
      pressure_pending = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed rows; apply any mode write ahead of its byte.
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (directed_rows[i].act == MODE_NARROW)
            switch_mode(1'b1);
         else if (directed_rows[i].act == MODE_WIDE)
            switch_mode(1'b0);
         feed(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].res);
      end

      // First random phase opens with the long result hold-off, so the block
      // fills and stalls its input while bytes keep coming.
      random_phase(1'b0, 1'b1);
      random_phase(1'b1);
      random_phase(1'b0);
      random_phase(1'b1);

      // Drain: drop valid, wait for every prediction, then keep the clock
      // running to catch any stray result.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS utf8_stream_decoder_unit");
      else
         $display("FAIL utf8_stream_decoder_unit");
      $finish;
   end

endmodule

>>> sim.f
sv/utf8sd_pkg.sv
sv/utf8sd_step.sv
sv/utf8_stream_decoder_unit.sv
sv/utf8sd_checker.sv
verif/utf8_stream_decoder_unit_test.sv
